// ===== src/rkd_pkg.sv =====
// Shared types and constants for the RK number decoder.
// No dependencies; every other file of the block imports this package.
package rkd_pkg;

    // Field widths of the request and the result.
    localparam int WORD_W  = 32;
    localparam int PAY_W   = 30;
    localparam int REAL_W  = 64;
    // Signed exponent carried through the divide path.
    localparam int EXP_W   = 13;
    // An unscaled double payload sits above this many zero bits.
    localparam int DBL_LOW_ZERO = 34;

    // Reciprocal of 25 for a 30-bit dividend: q = (n * RECIP_25) >> RECIP_SHIFT.
    localparam logic [30:0] RECIP_25    = 31'd1374389535;
    localparam int          RECIP_SHIFT = 35;
    // (2^20 - 1) / 25: one 20-bit period of the binary fraction r/25 is r times this.
    localparam logic [15:0] PERIOD_25   = 16'd41943;
    // Maps the exponent of the normalized dividend to the biased result exponent
    // (bias 1023, minus 29 for the dividend scale, minus 2 for the divide by 4).
    localparam logic signed [EXP_W-1:0] BIAS_ADJ = 13'sd992;
    localparam logic [REAL_W-1:0] QUIET_BIT = 64'h0008_0000_0000_0000;

    // How a request turns into its result.
    typedef enum logic [1:0] {
        KIND_INT,   // integer without scale: integer result
        KIND_RAW,   // double bits pass through unchanged
        KIND_NAN,   // scaled NaN: pass through with the quiet bit set
        KIND_DIV    // finite nonzero value divided by 100
    } kind_t;

    // Control that travels alongside the data in every stage.
    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic             sign;
        logic [PAY_W-1:0] payload;
    } ctl_t;

endpackage

// ===== src/rkd_unpack.sv =====
// First stage: splits the RK word, classifies the request and sets up the
// dividend and its exponent. Depends on rkd_pkg.
module rkd_unpack
    import rkd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [WORD_W-1:0]       rk_word,
    output ctl_t                    ctl,
    output logic [PAY_W-1:0]        w,
    output logic signed [EXP_W-1:0] p0
);

    logic                    scale;
    logic                    int_flag;
    logic [PAY_W-1:0]        pay;
    logic [10:0]             exp_f;
    logic [17:0]             frac_f;
    ctl_t                    ctl_next;
    logic [PAY_W-1:0]        w_next;
    logic signed [EXP_W-1:0] p0_next;
    logic                    valid_reg;
    ctl_t                    ctl_data_reg;
    logic [PAY_W-1:0]        w_reg;
    logic signed [EXP_W-1:0] p0_reg;

    assign scale    = rk_word[0];
    assign int_flag = rk_word[1];
    assign pay      = rk_word[WORD_W-1:2];
    assign exp_f    = pay[28:18];
    assign frac_f   = pay[17:0];

    // Classify the request and place the significand with its leading bit
    // at or below bit 29; p0 is the exponent of bit 29.
    always_comb
    begin
        ctl_next         = '0;
        ctl_next.valid   = in_valid;
        ctl_next.kind    = KIND_RAW;
        ctl_next.payload = pay;
        w_next           = '0;
        p0_next          = '0;
        if (int_flag && !scale)
        begin
            ctl_next.kind = KIND_INT;
        end
        else if (int_flag)
        begin
            // Scaled integer: magnitude and sign; zero gives +0.0.
            ctl_next.sign = pay[PAY_W-1];
            w_next        = pay[PAY_W-1] ? (~pay + 30'd1) : pay;
            p0_next       = 13'sd29;
            if (pay != '0)
            begin
                ctl_next.kind = KIND_DIV;
            end
        end
        else if (scale)
        begin
            ctl_next.sign = pay[PAY_W-1];
            if (exp_f == 11'h7FF)
            begin
                // Infinity keeps its bits; a NaN is made quiet.
                if (frac_f != '0)
                begin
                    ctl_next.kind = KIND_NAN;
                end
            end
            else if (exp_f != '0 || frac_f != '0)
            begin
                ctl_next.kind = KIND_DIV;
                w_next        = {(exp_f != '0), frac_f, 11'd0};
                p0_next       = (exp_f != '0) ?
                                ($signed({2'b00, exp_f}) - 13'sd1023) : -13'sd1022;
            end
        end
    end

    // Valid bit under reset; the rest of the stage is plain data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_data_reg <= ctl_next;
        w_reg        <= w_next;
        p0_reg       <= p0_next;
    end

    always_comb
    begin
        ctl       = ctl_data_reg;
        ctl.valid = valid_reg;
    end

    assign w  = w_reg;
    assign p0 = p0_reg;

endmodule

// ===== src/rkd_norm.sv =====
// Second stage: leading-zero count and left shift of the 30-bit dividend.
// Depends on rkd_pkg.
module rkd_norm
    import rkd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_t                    ctl_in,
    input  logic [PAY_W-1:0]        w,
    input  logic signed [EXP_W-1:0] p0,
    output ctl_t                    ctl_out,
    output logic [PAY_W-1:0]        n,
    output logic signed [EXP_W-1:0] p
);

    logic [4:0]              lz;
    logic [PAY_W-1:0]        n_next;
    logic signed [EXP_W-1:0] p_next;
    logic                    valid_reg;
    ctl_t                    ctl_reg;
    logic [PAY_W-1:0]        n_reg;
    logic signed [EXP_W-1:0] p_reg;

    // Priority encoder: the highest set bit wins.
    always_comb
    begin
        lz = '0;
        for (int i = 0; i < PAY_W; i++)
        begin
            if (w[i])
            begin
                lz = 5'(PAY_W - 1 - i);
            end
        end
    end

    // Shift the leading one to bit 29 and adjust the exponent to match.
    assign n_next = w << lz;
    assign p_next = p0 - $signed({8'd0, lz});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_in;
        n_reg   <= n_next;
        p_reg   <= p_next;
    end

    always_comb
    begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign n = n_reg;
    assign p = p_reg;

endmodule

// ===== src/rkd_div25.sv =====
// Stages three to five: divides the normalized dividend by 25 with a
// reciprocal multiply, then expands the remainder into 64 fraction bits.
// Depends on rkd_pkg.
module rkd_div25
    import rkd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_t                    ctl_in,
    input  logic [PAY_W-1:0]        n,
    input  logic signed [EXP_W-1:0] p,
    output ctl_t                    ctl_out,
    output logic [89:0]             y,
    output logic                    rem_nz,
    output logic signed [EXP_W-1:0] b
);

    // Stage three: reciprocal product.
    logic [2:0]              valid_reg;
    ctl_t                    ctl3_reg;
    ctl_t                    ctl4_reg;
    ctl_t                    ctl5_reg;
    logic [60:0]             prod_reg;
    logic [PAY_W-1:0]        n3_reg;
    logic signed [EXP_W-1:0] p3_reg;
    // Stage four: quotient and remainder.
    logic [25:0]             q_next;
    logic [30:0]             q25;
    logic [30:0]             rem_full;
    logic [25:0]             q_reg;
    logic [4:0]              r_reg;
    logic signed [EXP_W-1:0] p4_reg;
    // Stage five: fraction and normalization.
    logic [20:0]             period;
    logic [63:0]             frac;
    logic                    lead;
    logic [89:0]             y_next;
    logic signed [EXP_W-1:0] b_next;
    logic [89:0]             y_reg;
    logic                    rem_nz_reg;
    logic signed [EXP_W-1:0] b_reg;

    // The quotient of a 30-bit value by 25 is exact with this reciprocal.
    assign q_next   = prod_reg[60:RECIP_SHIFT];
    assign q25      = {5'd0, q_next} * 31'd25;
    assign rem_full = {1'b0, n3_reg} - q25;

    // r/25 repeats with a period of 20 bits, so three periods plus four bits
    // give the first 64 fraction bits; the tail is nonzero exactly when r is.
    assign period = {16'd0, r_reg} * {5'd0, PERIOD_25};
    assign frac   = {period[19:0], period[19:0], period[19:0], period[19:16]};
    assign lead   = q_reg[25];
    assign y_next = lead ? {q_reg, frac} : {q_reg[24:0], frac, 1'b0};
    assign b_next = p4_reg + BIAS_ADJ + (lead ? 13'sd25 : 13'sd24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], ctl_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ctl3_reg   <= ctl_in;
        prod_reg   <= {31'd0, n} * {30'd0, RECIP_25};
        n3_reg     <= n;
        p3_reg     <= p;
        ctl4_reg   <= ctl3_reg;
        q_reg      <= q_next;
        r_reg      <= rem_full[4:0];
        p4_reg     <= p3_reg;
        ctl5_reg   <= ctl4_reg;
        y_reg      <= y_next;
        rem_nz_reg <= (r_reg != '0);
        b_reg      <= b_next;
    end

    always_comb
    begin
        ctl_out       = ctl5_reg;
        ctl_out.valid = valid_reg[2];
    end

    assign y      = y_reg;
    assign rem_nz = rem_nz_reg;
    assign b      = b_reg;

endmodule

// ===== src/rkd_round.sv =====
// Stages six and seven: denormalizing shift, round to nearest even and the
// final result select. Depends on rkd_pkg.
module rkd_round
    import rkd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_t                    ctl_in,
    input  logic [89:0]             y,
    input  logic                    rem_nz,
    input  logic signed [EXP_W-1:0] b,
    output logic                    done,
    output logic                    is_integer,
    output logic signed [PAY_W-1:0] int_field,
    output logic [REAL_W-1:0]       real_bits
);

    logic                    normal;
    logic signed [EXP_W-1:0] sh_full;
    logic [5:0]              sh;
    logic [126:0]            zx;
    logic [51:0]             frac52;
    logic [10:0]             exp_field;
    logic                    guard;
    logic                    sticky;
    logic                    valid6_reg;
    ctl_t                    ctl6_reg;
    logic [REAL_W-1:0]       body_reg;
    logic                    inc_reg;
    logic [REAL_W-1:0]       rounded;
    logic                    is_integer_next;
    logic signed [PAY_W-1:0] int_field_next;
    logic [REAL_W-1:0]       real_bits_next;
    logic                    done_reg;
    logic                    is_integer_reg;
    logic signed [PAY_W-1:0] int_field_reg;
    logic [REAL_W-1:0]       real_bits_reg;

    // Below the normal range the significand moves right by 1 - b places.
    assign normal    = (b > 13'sd0);
    assign sh_full   = 13'sd1 - b;
    assign sh        = normal ? 6'd0 : ((sh_full > 13'sd63) ? 6'd63 : sh_full[5:0]);
    assign exp_field = normal ? b[10:0] : 11'd0;
    assign zx        = {y, 37'd0} >> sh;
    assign frac52    = zx[125:74];
    assign guard     = zx[73];
    assign sticky    = (zx[72:0] != '0) || rem_nz;

    // A carry out of the fraction moves correctly into the exponent field.
    assign rounded = body_reg + {63'd0, inc_reg};

    // Final result select by request kind.
    always_comb
    begin
        is_integer_next = 1'b0;
        int_field_next  = '0;
        real_bits_next  = '0;
        case (ctl6_reg.kind)
            KIND_INT:
            begin
                is_integer_next = 1'b1;
                int_field_next  = $signed(ctl6_reg.payload);
            end
            KIND_RAW:
            begin
                real_bits_next = {ctl6_reg.payload, {DBL_LOW_ZERO{1'b0}}};
            end
            KIND_NAN:
            begin
                real_bits_next = {ctl6_reg.payload, {DBL_LOW_ZERO{1'b0}}} | QUIET_BIT;
            end
            KIND_DIV:
            begin
                real_bits_next = rounded;
            end
            default:
            begin
                real_bits_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid6_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid6_reg <= ctl_in.valid;
            done_reg   <= valid6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl6_reg       <= ctl_in;
        body_reg       <= {ctl_in.sign, exp_field, frac52};
        inc_reg        <= guard & (sticky | frac52[0]);
        is_integer_reg <= is_integer_next;
        int_field_reg  <= int_field_next;
        real_bits_reg  <= real_bits_next;
    end

    assign done       = done_reg;
    assign is_integer = is_integer_reg;
    assign int_field  = int_field_reg;
    assign real_bits  = real_bits_reg;

endmodule

// ===== src/rk_number_decoder_top.sv =====
// RK number decoder: a request is taken in every cycle and its result
// appears on done, one result per request, in order. The path has seven
// register stages: unpack, normalize, reciprocal multiply, remainder,
// fraction expand, shift and round, output select. busy is always low and
// results cannot be held off.
// Top level; depends on rkd_pkg, rkd_unpack, rkd_norm, rkd_div25, rkd_round.
module rk_number_decoder_top
    import rkd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [WORD_W-1:0]       rk_word,
    output logic                    done,
    output logic                    is_integer,
    output logic signed [PAY_W-1:0] int_field,
    output logic [REAL_W-1:0]       real_bits
);

    ctl_t                    ctl1;
    ctl_t                    ctl2;
    ctl_t                    ctl5;
    logic [PAY_W-1:0]        w;
    logic signed [EXP_W-1:0] p0;
    logic [PAY_W-1:0]        n;
    logic signed [EXP_W-1:0] p;
    logic [89:0]             y;
    logic                    rem_nz;
    logic signed [EXP_W-1:0] b;

    // The pipeline never stalls.
    assign busy = 1'b0;

    rkd_unpack u_unpack
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .rk_word  (rk_word),
        .ctl      (ctl1),
        .w        (w),
        .p0       (p0)
    );

    rkd_norm u_norm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl1),
        .w       (w),
        .p0      (p0),
        .ctl_out (ctl2),
        .n       (n),
        .p       (p)
    );

    rkd_div25 u_div25
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl2),
        .n       (n),
        .p       (p),
        .ctl_out (ctl5),
        .y       (y),
        .rem_nz  (rem_nz),
        .b       (b)
    );

    rkd_round u_round
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (ctl5),
        .y          (y),
        .rem_nz     (rem_nz),
        .b          (b),
        .done       (done),
        .is_integer (is_integer),
        .int_field  (int_field),
        .real_bits  (real_bits)
    );

endmodule
